// ===== rtl/core/bcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants for the button click classifier
// Event codes, configuration register indexes, reset values and the
// per-tick scan result passed from the debouncer to the click engine.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned MsW   = 16;
	localparam int unsigned CntW  = 2;
	localparam int unsigned IdxW  = 2;

	// pending event codes
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2
	} event_t;

	// configuration register indexes
	typedef enum logic [IdxW-1:0] {
		CFG_ENABLE   = 2'd0,
		CFG_DEBOUNCE = 2'd1,
		CFG_DBLCLICK = 2'd2
	} cfg_idx_t;

	localparam logic           RstEnable   = 1'b0;
	localparam logic [MsW-1:0] RstDebounce = 16'd50;
	localparam logic [MsW-1:0] RstDblClick = 16'd500;
	localparam logic           LvlReleased = 1'b1;

	// debouncer result for one tick
	typedef struct packed {
		logic             pressed;     // debounced change to low
		logic             deb_level;   // next debounced level
		logic [TimeW-1:0] change_time; // next raw change time
	} scan_t;

	// engine status seen by the top level
	typedef struct packed {
		event_t pending;     // pending event held in state
		logic   cnt_is_zero; // no press waiting for classification
	} eng_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/bcc_debounce.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_debounce: combinational debounce step
// Tracks raw level changes and accepts a level once it has been stable
// longer than the debounce time; flags a debounced press.
// ----------------------------------------------------------------------------
module bcc_debounce (
	input  wire logic                        raw,
	input  wire logic [bcc_pkg::TimeW-1:0]   now_ms,
	input  wire logic                        previous_raw,
	input  wire logic                        deb_level,
	input  wire logic [bcc_pkg::TimeW-1:0]   change_time,
	input  wire logic [bcc_pkg::MsW-1:0]     debounce_ms,
	output bcc_pkg::scan_t                   scan
);

	logic                      raw_chg;
	logic [bcc_pkg::TimeW-1:0] ct_nxt;
	logic [bcc_pkg::TimeW-1:0] elapsed;
	logic                      stable_ok;

	// restart the stability timer on any raw change
	always_comb begin
		raw_chg   = (raw != previous_raw);
		ct_nxt    = raw_chg ? now_ms : change_time;
		elapsed   = now_ms - ct_nxt;
		stable_ok = (elapsed > {{(bcc_pkg::TimeW-bcc_pkg::MsW){1'b0}}, debounce_ms});
	end

	// accept the level and detect a press
	always_comb begin
		scan.change_time = ct_nxt;
		scan.deb_level   = stable_ok ? raw : deb_level;
		scan.pressed     = stable_ok && (raw != deb_level) && !raw;
	end

endmodule
`default_nettype wire

// ===== rtl/core/bcc_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_engine: click classification state
// Holds the debounce and press state, applies the acknowledge, counts
// presses and raises single and double click events, one tick per step.
// ----------------------------------------------------------------------------
module bcc_engine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic                       raw,
	input  wire logic [bcc_pkg::TimeW-1:0]  now_ms,
	input  wire logic                       ack,
	input  wire logic                       enable,
	input  wire logic [bcc_pkg::MsW-1:0]    debounce_ms,
	input  wire logic [bcc_pkg::MsW-1:0]    double_click_ms,
	output bcc_pkg::event_t                 event_nxt,
	output logic                            level_nxt,
	output bcc_pkg::eng_stat_t              stat
);

	logic                      prev_raw_q;
	logic                      deb_level_q;
	logic [bcc_pkg::TimeW-1:0] change_time_q;
	logic [bcc_pkg::CntW-1:0]  press_cnt_q;
	logic [bcc_pkg::TimeW-1:0] press_time_q;
	bcc_pkg::event_t           pending_q;

	bcc_pkg::scan_t            scan;
	bcc_pkg::event_t           pend_ack;
	logic                      scan_en;
	logic [bcc_pkg::CntW-1:0]  cnt_inc;
	logic [bcc_pkg::TimeW-1:0] ptime_inc;
	logic [bcc_pkg::TimeW-1:0] since_press;
	logic [bcc_pkg::CntW-1:0]  cnt_nxt;
	logic [bcc_pkg::TimeW-1:0] ptime_nxt;
	logic                      prev_raw_nxt;
	logic [bcc_pkg::TimeW-1:0] ct_nxt;

	bcc_debounce u_debounce (
		.raw          (raw),
		.now_ms       (now_ms),
		.previous_raw (prev_raw_q),
		.deb_level    (deb_level_q),
		.change_time  (change_time_q),
		.debounce_ms  (debounce_ms),
		.scan         (scan)
	);

	// acknowledge first, then scan only when enabled with nothing pending
	always_comb begin
		pend_ack = ack ? bcc_pkg::EV_NONE : pending_q;
		scan_en  = enable && (pend_ack == bcc_pkg::EV_NONE);
	end

	// press counting and classification
	always_comb begin
		cnt_inc     = scan.pressed ? press_cnt_q + 1'b1 : press_cnt_q;
		ptime_inc   = scan.pressed ? now_ms : press_time_q;
		since_press = now_ms - ptime_inc;
		event_nxt   = pend_ack;
		cnt_nxt     = press_cnt_q;
		ptime_nxt   = press_time_q;
		prev_raw_nxt = prev_raw_q;
		level_nxt   = deb_level_q;
		ct_nxt      = change_time_q;
		if (scan_en) begin
			prev_raw_nxt = raw;
			level_nxt    = scan.deb_level;
			ct_nxt       = scan.change_time;
			cnt_nxt      = cnt_inc;
			ptime_nxt    = ptime_inc;
			if (cnt_inc == 2'd1) begin
				if (since_press >
					{{(bcc_pkg::TimeW-bcc_pkg::MsW){1'b0}}, double_click_ms}) begin
					event_nxt = bcc_pkg::EV_SINGLE;
					cnt_nxt   = '0;
					ptime_nxt = '0;
				end
			end else if (cnt_inc == 2'd2) begin
				event_nxt = bcc_pkg::EV_DOUBLE;
				cnt_nxt   = '0;
			end
		end
	end

	// state registers, updated once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q    <= bcc_pkg::LvlReleased;
			deb_level_q   <= bcc_pkg::LvlReleased;
			change_time_q <= '0;
			press_cnt_q   <= '0;
			press_time_q  <= '0;
			pending_q     <= bcc_pkg::EV_NONE;
		end else if (step) begin
			prev_raw_q    <= prev_raw_nxt;
			deb_level_q   <= level_nxt;
			change_time_q <= ct_nxt;
			press_cnt_q   <= cnt_nxt;
			press_time_q  <= ptime_nxt;
			pending_q     <= event_nxt;
		end
	end

	always_comb begin
		stat.pending     = pending_q;
		stat.cnt_is_zero = (press_cnt_q == '0);
	end

endmodule
`default_nettype wire

// ===== rtl/core/button_click_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_classifier: debounced single and double click detector
// Input register, one-pass classification logic and an output register.
// ----------------------------------------------------------------------------
// Each request is one scan tick (raw active-low level, millisecond time,
// acknowledge) and yields exactly one result (pending event, debounced
// level). A tick goes from the input register through the click engine to
// the output register; one tick can be accepted every cycle unless the
// result channel stalls, as the engine updates its state once per tick.
// The output register lets a new request enter while a finished result
// waits. Configuration writes take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module button_click_classifier (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         cfg_we,
	input  wire logic [bcc_pkg::IdxW-1:0]     cfg_index,
	input  wire logic [bcc_pkg::MsW-1:0]      cfg_data,
	// request channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         button_level,
	input  wire logic [bcc_pkg::TimeW-1:0]    now_ms,
	input  wire logic                         event_ack,
	// result channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [1:0]                        event_code,
	output logic                              stable_level
);

	logic                      enable_q;
	logic [bcc_pkg::MsW-1:0]   debounce_q;
	logic [bcc_pkg::MsW-1:0]   dblclick_q;

	logic                      valid_s1;
	logic                      raw_s1;
	logic [bcc_pkg::TimeW-1:0] now_s1;
	logic                      ack_s1;

	logic                      out_valid_q;
	bcc_pkg::event_t           event_q;
	logic                      level_q;

	logic                      out_free;
	logic                      advance;
	logic                      in_take;
	bcc_pkg::event_t           event_nxt;
	logic                      level_nxt;
	bcc_pkg::eng_stat_t        stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= bcc_pkg::RstEnable;
			debounce_q <= bcc_pkg::RstDebounce;
			dblclick_q <= bcc_pkg::RstDblClick;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcc_pkg::CFG_ENABLE:   enable_q   <= cfg_data[0];
				bcc_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data;
				bcc_pkg::CFG_DBLCLICK: dblclick_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake control
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		advance  = valid_s1 && out_free;
		in_stall = valid_s1 && !out_free;
		in_take  = in_valid && !in_stall;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			raw_s1 <= button_level;
			now_s1 <= now_ms;
			ack_s1 <= event_ack;
		end
	end

	bcc_engine u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.raw             (raw_s1),
		.now_ms          (now_s1),
		.ack             (ack_s1),
		.enable          (enable_q),
		.debounce_ms     (debounce_q),
		.double_click_ms (dblclick_q),
		.event_nxt       (event_nxt),
		.level_nxt       (level_nxt),
		.stat            (stat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= event_nxt;
			level_q <= level_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_code   = event_q;
	assign stable_level = level_q;

	// stall only while a tick waits behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("request stalled without a blocked result");

	// a processed tick always shows up as a result
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_valid && (event_code == $past(event_nxt))))
		else $error("processed tick did not reach the result register");

	// an unacknowledged event stays pending
	a_event_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !ack_s1 && (stat.pending != bcc_pkg::EV_NONE))
		|=> (event_code == $past(stat.pending)))
		else $error("pending event changed without acknowledge");

	// an event leaves no press waiting
	a_event_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.pending != bcc_pkg::EV_NONE) |-> stat.cnt_is_zero)
		else $error("press count not cleared with pending event");

endmodule
`default_nettype wire
